FILE: hdl/tst_pkg.sv
package tst_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

   localparam int REQ_DATA_W = 216;
   localparam int RSP_DATA_W = 96;

   localparam logic [1:0] MODE_REGISTER = 2'd0;
   localparam logic [1:0] MODE_CANCEL   = 2'd1;
   localparam logic [1:0] MODE_POLL     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } tst_state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] now_us;
      logic [31:0] delay_sec;
      logic [31:0] delay_usec;
      logic [15:0] handler_id;
      logic [31:0] ctx_tag;
      logic [31:0] arg_tag;
      logic        ctx_any;
      logic        arg_any;
   } tst_req_type;

   typedef struct packed {
      logic [63:0] due;
      logic [31:0] ctx;
      logic [31:0] arg;
      logic [15:0] handler;
   } tst_entry_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  slot_used;
      logic [4:0]  cancel_count;
      logic        fired;
      logic [15:0] fired_handler;
      logic [31:0] fired_ctx;
      logic [31:0] fired_arg;
      logic        last;
   } tst_rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tst_mem_ctl_type;

endpackage

FILE: hdl/tst_slot_mem.sv
module tst_slot_mem #(
   parameter int SLOT_COUNT = tst_pkg::SLOT_COUNT_DEF
) (
   input  logic                            clock,
   input  tst_pkg::tst_mem_ctl_type        ctl,
   input  logic [$clog2(SLOT_COUNT)-1:0]   rd_idx,
   input  logic [$clog2(SLOT_COUNT)-1:0]   wr_idx,
   input  tst_pkg::tst_entry_type          wr_data,
   output tst_pkg::tst_entry_type          rd_data
);

   tst_pkg::tst_entry_type mem [SLOT_COUNT];
   tst_pkg::tst_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tst_out_reg.sv
module tst_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tst_pkg::tst_rsp_type load_rsp,
   output logic                 load_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tst_pkg::tst_rsp_type rsp
);

   logic                 valid_ff;
   logic                 valid_in;
   tst_pkg::tst_rsp_type rsp_ff;

   assign load_ok = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= load_rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: hdl/tst_seq.sv
module tst_seq #(
   parameter int SLOT_COUNT = tst_pkg::SLOT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tst_pkg::tst_req_type            req_item,
   output tst_pkg::tst_mem_ctl_type        mem_ctl,
   output logic [$clog2(SLOT_COUNT)-1:0]   rd_idx,
   output logic [$clog2(SLOT_COUNT)-1:0]   wr_idx,
   output tst_pkg::tst_entry_type          wr_data,
   input  tst_pkg::tst_entry_type          rd_data,
   output logic                            load,
   output tst_pkg::tst_rsp_type            load_rsp,
   input  logic                            load_ok
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);

   tst_pkg::tst_state_type  state_ff, state_in;
   tst_pkg::tst_req_type    item_ff;
   logic [63:0]             base_ff;
   logic [51:0]             prod_ff;
   logic [CNT_W-1:0]        rd_cnt_ff, rd_cnt_in;
   logic [IDX_W-1:0]        eval_idx_ff;
   logic                    eval_vld_ff, eval_vld_in;
   logic [SLOT_COUNT-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_vld_ff, pend_vld_in;
   tst_pkg::tst_rsp_type    pend_ff;

   logic                    accept;
   logic                    occ;
   logic                    is_last;
   logic [63:0]             due;
   logic                    hit_c;
   logic                    hit_p;
   logic [CNT_W-1:0]        cnt_sum;
   logic [IDX_W+3:0]        idx_ext;
   logic [CNT_W+4:0]        cnt_ext;
   tst_pkg::tst_rsp_type    fire_rsp;

   logic                    need_emit;
   tst_pkg::tst_rsp_type    emit_rsp;
   logic                    finish;
   logic                    to_flush;
   logic                    wr_req;
   logic                    occ_set;
   logic                    occ_clr;
   logic                    pend_load;
   logic                    cnt_add;
   logic                    go;
   logic                    rd_en;

   assign accept    = (state_ff == tst_pkg::ST_IDLE) && req_valid;
   assign req_ready = (state_ff == tst_pkg::ST_IDLE);

   assign occ     = occ_ff[eval_idx_ff];
   assign is_last = (eval_idx_ff == LAST_IDX);
   assign due     = base_ff + {12'd0, prod_ff};
   assign hit_c   = occ && (rd_data.handler == item_ff.handler_id)
                    && (item_ff.ctx_any || (rd_data.ctx == item_ff.ctx_tag))
                    && (item_ff.arg_any || (rd_data.arg == item_ff.arg_tag));
   assign hit_p   = occ && (item_ff.now_us >= rd_data.due);
   assign cnt_sum = cnt_ff + {{(CNT_W-1){1'b0}}, hit_c};
   assign idx_ext = {4'd0, eval_idx_ff};
   assign cnt_ext = {5'd0, cnt_sum};

   always_comb begin
      fire_rsp               = '0;
      fire_rsp.slot_used     = idx_ext[3:0];
      fire_rsp.fired         = 1'b1;
      fire_rsp.fired_handler = rd_data.handler;
      fire_rsp.fired_ctx     = rd_data.ctx;
      fire_rsp.fired_arg     = rd_data.arg;
   end

   always_comb begin
      need_emit = 1'b0;
      emit_rsp  = '0;
      finish    = 1'b0;
      to_flush  = 1'b0;
      wr_req    = 1'b0;
      occ_set   = 1'b0;
      occ_clr   = 1'b0;
      pend_load = 1'b0;
      cnt_add   = 1'b0;
      if (state_ff == tst_pkg::ST_SCAN && eval_vld_ff) begin
         unique case (item_ff.mode)
            tst_pkg::MODE_REGISTER: begin
               if (!occ) begin
                  wr_req             = 1'b1;
                  occ_set            = (item_ff.handler_id != 16'd0);
                  need_emit          = 1'b1;
                  emit_rsp.slot_used = idx_ext[3:0];
                  emit_rsp.last      = 1'b1;
                  finish             = 1'b1;
               end else if (is_last) begin
                  need_emit       = 1'b1;
                  emit_rsp.status = 1'b1;
                  emit_rsp.last   = 1'b1;
                  finish          = 1'b1;
               end
            end
            tst_pkg::MODE_CANCEL: begin
               cnt_add = hit_c;
               occ_clr = hit_c;
               if (is_last) begin
                  need_emit             = 1'b1;
                  emit_rsp.cancel_count = cnt_ext[4:0];
                  emit_rsp.last         = 1'b1;
                  finish                = 1'b1;
               end
            end
            tst_pkg::MODE_POLL: begin
               if (hit_p) begin
                  occ_clr   = 1'b1;
                  pend_load = 1'b1;
                  need_emit = pend_vld_ff;
                  emit_rsp  = pend_ff;
               end
               to_flush = is_last;
            end
            default: begin
               need_emit     = 1'b1;
               emit_rsp.last = 1'b1;
               finish        = 1'b1;
            end
         endcase
      end else if (state_ff == tst_pkg::ST_FLUSH) begin
         need_emit = 1'b1;
         if (pend_vld_ff) begin
            emit_rsp = pend_ff;
         end
         emit_rsp.last = 1'b1;
         finish        = 1'b1;
      end
   end

   assign go    = !need_emit || load_ok;
   assign load  = need_emit && load_ok;
   assign rd_en = (state_ff == tst_pkg::ST_SCAN) && go && (rd_cnt_ff != CNT_END)
                  && !(eval_vld_ff && (finish || to_flush));

   assign load_rsp      = emit_rsp;
   assign mem_ctl.rd_en = rd_en;
   assign mem_ctl.wr_en = wr_req && go;
   assign rd_idx        = rd_cnt_ff[IDX_W-1:0];
   assign wr_idx        = eval_idx_ff;
   assign wr_data       = '{due: due, ctx: item_ff.ctx_tag, arg: item_ff.arg_tag,
                            handler: item_ff.handler_id};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tst_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tst_pkg::ST_SCAN;
            end
         end
         tst_pkg::ST_SCAN: begin
            if (eval_vld_ff && go && finish) begin
               state_in = tst_pkg::ST_IDLE;
            end else if (eval_vld_ff && go && to_flush) begin
               state_in = tst_pkg::ST_FLUSH;
            end
         end
         tst_pkg::ST_FLUSH: begin
            if (load_ok) begin
               state_in = tst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_cnt_in   = rd_cnt_ff;
      eval_vld_in = eval_vld_ff;
      occ_in      = occ_ff;
      cnt_in      = cnt_ff;
      pend_vld_in = pend_vld_ff;
      if (accept) begin
         rd_cnt_in   = '0;
         eval_vld_in = 1'b0;
         cnt_in      = '0;
         pend_vld_in = 1'b0;
      end else if (state_ff == tst_pkg::ST_SCAN && go) begin
         eval_vld_in = rd_en;
         if (rd_en) begin
            rd_cnt_in = rd_cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
         end
         if (cnt_add) begin
            cnt_in = cnt_sum;
         end
         if (occ_set) begin
            occ_in[eval_idx_ff] = 1'b1;
         end
         if (occ_clr) begin
            occ_in[eval_idx_ff] = 1'b0;
         end
         if (pend_load) begin
            pend_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tst_pkg::ST_IDLE;
         rd_cnt_ff   <= '0;
         eval_vld_ff <= 1'b0;
         occ_ff      <= '0;
         cnt_ff      <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_cnt_ff   <= rd_cnt_in;
         eval_vld_ff <= eval_vld_in;
         occ_ff      <= occ_in;
         cnt_ff      <= cnt_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= item_ff.delay_sec * tst_pkg::USEC_PER_SEC;
      if (accept) begin
         item_ff <= req_item;
         base_ff <= req_item.now_us + {32'd0, req_item.delay_usec};
      end
      if (rd_en) begin
         eval_idx_ff <= rd_cnt_ff[IDX_W-1:0];
      end
      if (state_ff == tst_pkg::ST_SCAN && go && pend_load) begin
         pend_ff <= fire_rsp;
      end
   end

endmodule

FILE: hdl/timeout_slot_table.sv
// Table of SLOT_COUNT software timeout slots behind a request and a response stream.
// req_tuser selects the item kind: register stores handler, tags and a due time of
// now + sec*1000000 + usec in the lowest free slot; cancel frees every slot whose
// handler matches and whose tags match or are wildcarded; poll fires and frees every
// occupied slot that is due, one response each in slot order, or one empty response.
// The slots live in one memory with a single read port and a registered read, scanned
// one slot per cycle while the response side does not stall; a new item is taken only
// once the last one is done. Every response except a fired timer that is not the last
// of its poll ends its item with rsp_tlast set.
module timeout_slot_table #(
   parameter int SLOT_COUNT = tst_pkg::SLOT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // now_us, delay_sec, delay_usec, handler_id, ctx_tag, arg_tag, ctx_any, arg_any
   input  logic [tst_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, slot_used, cancel_count, fired_handler, fired_ctx, fired_arg
   output logic [tst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // fired
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IDX_W = $clog2(SLOT_COUNT);

   tst_pkg::tst_req_type      req_item;
   tst_pkg::tst_mem_ctl_type  mem_ctl;
   logic [IDX_W-1:0]          rd_idx;
   logic [IDX_W-1:0]          wr_idx;
   tst_pkg::tst_entry_type    wr_data;
   tst_pkg::tst_entry_type    rd_data;
   logic                      load;
   tst_pkg::tst_rsp_type      load_rsp;
   logic                      load_ok;
   tst_pkg::tst_rsp_type      rsp;

   assign req_item.mode       = req_tuser;
   assign req_item.now_us     = req_tdata[63:0];
   assign req_item.delay_sec  = req_tdata[95:64];
   assign req_item.delay_usec = req_tdata[127:96];
   assign req_item.handler_id = req_tdata[143:128];
   assign req_item.ctx_tag    = req_tdata[175:144];
   assign req_item.arg_tag    = req_tdata[207:176];
   assign req_item.ctx_any    = req_tdata[208];
   assign req_item.arg_any    = req_tdata[209];

   tst_seq #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .mem_ctl   (mem_ctl),
      .rd_idx    (rd_idx),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .load      (load),
      .load_rsp  (load_rsp),
      .load_ok   (load_ok)
   );

   tst_slot_mem #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_slot_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_idx  (rd_idx),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   tst_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_rsp  (load_rsp),
      .load_ok   (load_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.fired_arg, rsp.fired_ctx, rsp.fired_handler,
                       rsp.cancel_count, rsp.slot_used, rsp.status};
   assign rsp_tuser = rsp.fired;
   assign rsp_tlast = rsp.last;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request side ready right after an accepted item");

   a_unfired_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("non-fired response without last");

   a_fired_has_handler: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[25:10] != 16'd0))
      else $error("fired response from an empty slot");

endmodule
